@@ rtl/swhc_pkg.sv @@
// Shared widths, operation codes and sequencer states of the sliding-window hit counter.
// No dependencies; imported by sliding_window_hit_counter, its checker and its testbench.
`timescale 1ns / 1ps

package swhc_pkg;

  localparam int TS_BITS  = 32;
  localparam int OUT_BITS = 32;

  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_CHECK = 2'b10
  } state_t;

endpackage

@@ rtl/sliding_window_hit_counter.sv @@
// Sliding-window hit counter: a bucket queue in memory plus a running window total.
// Depends on swhc_pkg.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     in_valid / in_stall  op, timestamp
// output    out_valid / out_stall hit_count (queries only)
//
// An item moves from the idle to the check state, which first pops expired
// one-second buckets from the head of the bucket memory (one memory read per cycle).
// Each bucket is popped once, and the bucket memory needs no clearing pass on reset.
// A finished query waits in the output register; hits go on meanwhile, but the
// next query holds in the check state until the register frees and stalls the input.

module sliding_window_hit_counter import swhc_pkg::*; #(
  parameter int WINDOW     = 300,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [TS_BITS-1:0]  timestamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] hit_count
);

  localparam int AW    = $clog2(WINDOW);
  localparam int DEPTH = 1 << AW;
  localparam int TB    = COUNT_BITS + AW;
  localparam int WB    = (TB > OUT_BITS) ? TB : OUT_BITS + 1;

  typedef struct packed {
    logic [TS_BITS-1:0]    sec;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  entry_t mem [DEPTH];
  entry_t q;

  state_t                state, state_next;
  logic                  cur_op, cur_op_next;
  logic [TS_BITS-1:0]    cur_time, cur_time_next;
  logic [TS_BITS-1:0]    last_time, last_time_next;
  logic [AW-1:0]         head_ptr, head_ptr_next;
  logic [AW-1:0]         tail_ptr, tail_ptr_next;
  logic [AW-1:0]         fill, fill_next;
  logic                  tail_valid, tail_valid_next;
  logic [TS_BITS-1:0]    tail_sec, tail_sec_next;
  logic [COUNT_BITS-1:0] tail_cnt, tail_cnt_next;
  logic [TB-1:0]         total, total_next;
  logic                  out_valid_next;
  logic [OUT_BITS-1:0]   hit_count_next;

  logic                  mem_we;
  logic [TS_BITS-1:0]    t_eff;
  logic                  head_expire;
  logic                  tail_expire;
  logic                  tail_live;
  logic                  out_free;
  logic [TB-1:0]         tot;
  logic [WB-1:0]         tot_wide;

  assign in_stall    = (state != S_IDLE);
  assign t_eff       = (timestamp < last_time) ? last_time : timestamp;
  assign head_expire = (fill != '0) && ((cur_time - q.sec) >= TS_BITS'(WINDOW));
  assign tail_expire = tail_valid && ((cur_time - tail_sec) >= TS_BITS'(WINDOW));
  assign tail_live   = tail_valid && !tail_expire;
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    state_next      = state;
    cur_op_next     = cur_op;
    cur_time_next   = cur_time;
    last_time_next  = last_time;
    head_ptr_next   = head_ptr;
    tail_ptr_next   = tail_ptr;
    fill_next       = fill;
    tail_valid_next = tail_valid;
    tail_sec_next   = tail_sec;
    tail_cnt_next   = tail_cnt;
    total_next      = total;
    out_valid_next  = out_valid && out_stall;
    hit_count_next  = hit_count;
    mem_we          = 1'b0;
    tot             = tail_expire ? total - TB'(tail_cnt) : total;
    tot_wide        = WB'(tot);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next     = S_CHECK;
          cur_op_next    = op;
          cur_time_next  = t_eff;
          last_time_next = t_eff;
        end
      end
      S_CHECK: begin
        if (head_expire) begin
          total_next    = total - TB'(q.cnt);
          head_ptr_next = head_ptr + AW'(1);
          fill_next     = fill - AW'(1);
        end else if (cur_op == OP_HIT) begin
          if (tail_live && (tail_sec == cur_time)) begin
            if (tail_cnt != '1) begin
              tail_cnt_next = tail_cnt + COUNT_BITS'(1);
              total_next    = tot + TB'(1);
            end else begin
              total_next = tot;
            end
          end else begin
            if (tail_live) begin
              mem_we        = 1'b1;
              tail_ptr_next = tail_ptr + AW'(1);
              fill_next     = fill + AW'(1);
            end
            tail_sec_next = cur_time;
            tail_cnt_next = COUNT_BITS'(1);
            total_next    = tot + TB'(1);
          end
          tail_valid_next = 1'b1;
          state_next      = S_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          hit_count_next  = (tot_wide > WB'({OUT_BITS{1'b1}})) ? '1 : tot_wide[OUT_BITS-1:0];
          total_next      = tot;
          tail_valid_next = tail_live;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_time  <= '0;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      fill       <= '0;
      tail_valid <= 1'b0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      last_time  <= last_time_next;
      head_ptr   <= head_ptr_next;
      tail_ptr   <= tail_ptr_next;
      fill       <= fill_next;
      tail_valid <= tail_valid_next;
      total      <= total_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op    <= cur_op_next;
    cur_time  <= cur_time_next;
    tail_sec  <= tail_sec_next;
    tail_cnt  <= tail_cnt_next;
    hit_count <= hit_count_next;
  end

  // The head is re-read every cycle, so a bucket pushed into an empty queue
  // is visible by the time the next item reaches the check state.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_ptr] <= '{sec: tail_sec, cnt: tail_cnt};
    end
    q <= mem[head_ptr_next];
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= AW'(WINDOW - 1))
    else $error("bucket queue holds more buckets than the window has seconds");

  assert property (@(posedge clk) disable iff (rst)
    (!tail_valid && (fill == '0)) |-> (total == '0))
    else $error("window total is nonzero with no buckets held");

  assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> (tail_sec <= last_time))
    else $error("newest bucket lies after the last transaction time");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_CHECK && cur_op == OP_QUERY))
    else $error("result produced without a query transaction");

endmodule

@@ verif/sliding_window_hit_counter_checker.sv @@
// Checker for the sliding-window hit counter: watches both channels, predicts each query's
// window count from the accepted transactions and compares it with the result channel.
// Depends on swhc_pkg.
`timescale 1ns / 1ps

module sliding_window_hit_counter_checker import swhc_pkg::*; #(
  parameter int WINDOW     = 300,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                op,
  input  logic [TS_BITS-1:0]  timestamp,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [OUT_BITS-1:0] hit_count,
  output int                  errors,
  output int                  pending,
  output int                  hits_seen,
  output int                  queries_seen,
  output int                  results_seen,
  output int                  clamped_seen,
  output int                  rollovers_seen,
  output int                  flushes_seen
);

  localparam logic [COUNT_BITS-1:0] SLOT_MAX  = '1;
  localparam logic [OUT_BITS-1:0]   TOTAL_MAX = '1;

  logic [COUNT_BITS-1:0] current_slots [1:WINDOW];
  logic [COUNT_BITS-1:0] previous_slots [1:WINDOW];
  logic [TS_BITS-1:0]    last_time;
  int unsigned           last_slot;
  logic [OUT_BITS-1:0]   expected_counts [$];
  logic [OUT_BITS-1:0]   oldest_count;
  int error_total, hit_total, query_total, result_total;
  int clamp_total, rollover_total, flush_total;

  task automatic apply_transaction(input logic kind, input logic [TS_BITS-1:0] ts);
    logic [TS_BITS-1:0] t;
    logic [TS_BITS-1:0] gap;
    int unsigned        slot;
    logic [64:0]        total;
    t = ts;
    if (t < last_time) begin
      t = last_time;
      clamp_total++;
    end
    slot = t % WINDOW;
    if (slot == 0) begin
      slot = WINDOW;
    end
    gap = t - last_time;
    if (gap > WINDOW) begin
      for (int i = 1; i <= WINDOW; i++) begin
        current_slots[i]  = '0;
        previous_slots[i] = '0;
      end
      flush_total++;
    end else if (slot < last_slot || (slot == last_slot && last_time < t)) begin
      for (int i = 1; i <= WINDOW; i++) begin
        previous_slots[i] = current_slots[i];
        current_slots[i]  = '0;
      end
      rollover_total++;
    end
    last_time = t;
    last_slot = slot;
    if (kind == OP_HIT) begin
      if (current_slots[slot] != SLOT_MAX) begin
        current_slots[slot] = current_slots[slot] + COUNT_BITS'(1);
      end
      hit_total++;
    end else begin
      total = '0;
      for (int i = 1; i <= WINDOW; i++) begin
        total = total + 65'((i <= slot) ? current_slots[i] : previous_slots[i]);
        if (total > 65'(TOTAL_MAX)) begin
          total = 65'(TOTAL_MAX);
        end
      end
      expected_counts.push_back(total[OUT_BITS-1:0]);
      query_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= WINDOW; i++) begin
        current_slots[i]  = '0;
        previous_slots[i] = '0;
      end
      last_time = '0;
      last_slot = 0;
      expected_counts.delete();
      error_total = 0;
      hit_total = 0;
      query_total = 0;
      result_total = 0;
      clamp_total = 0;
      rollover_total = 0;
      flush_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_total++;
        if (expected_counts.size() == 0) begin
          error_total++;
          $display("%0t: hit_count expected none (no query outstanding), actual %0d",
                   $time, hit_count);
        end else begin
          oldest_count = expected_counts.pop_front();
          if (hit_count !== oldest_count) begin
            error_total++;
            $display("%0t: hit_count expected %0d, actual %0d",
                     $time, oldest_count, hit_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_transaction(op, timestamp);
      end
    end
    errors         <= error_total;
    pending        <= expected_counts.size();
    hits_seen      <= hit_total;
    queries_seen   <= query_total;
    results_seen   <= result_total;
    clamped_seen   <= clamp_total;
    rollovers_seen <= rollover_total;
    flushes_seen   <= flush_total;
  end

endmodule

@@ verif/sliding_window_hit_counter_test.sv @@
// Testbench top for the sliding-window hit counter: drives hit and query transactions
// with random gaps and output stalls, and gives the verdict from the checker's error and pending counts.
// Depends on swhc_pkg, sliding_window_hit_counter and sliding_window_hit_counter_checker.
`timescale 1ns / 1ps

module sliding_window_hit_counter_test import swhc_pkg::*;;

  localparam int WINDOW       = 300;
  localparam int COUNT_BITS   = 32;
  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 530;
  localparam int DRAIN_CYCLES = WINDOW + 50;
  localparam int LONG_HOLD    = 400;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                op;
  logic [TS_BITS-1:0]  timestamp;
  logic                out_valid;
  logic                out_stall;
  logic [OUT_BITS-1:0] hit_count;

  int errors, pending, hits_seen, queries_seen, results_seen;
  int clamped_seen, rollovers_seen, flushes_seen;
  int sent_items;
  logic [TS_BITS-1:0] latest_time;
  logic calm;

  assign calm = ((sent_items / 64) % 4) == 3;

  sliding_window_hit_counter #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .timestamp (timestamp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit_count (hit_count)
  );

  sliding_window_hit_counter_checker #(
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .timestamp      (timestamp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit_count      (hit_count),
    .errors         (errors),
    .pending        (pending),
    .hits_seen      (hits_seen),
    .queries_seen   (queries_seen),
    .results_seen   (results_seen),
    .clamped_seen   (clamped_seen),
    .rollovers_seen (rollovers_seen),
    .flushes_seen   (flushes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [TS_BITS-1:0] later_time(input logic [TS_BITS-1:0] base,
                                                    input logic [TS_BITS-1:0] step);
    longint unsigned sum;
    sum = 64'(base) + 64'(step);
    return (sum > 64'hFFFF_FFFF) ? '1 : sum[TS_BITS-1:0];
  endfunction

  task automatic idle_gap();
    int n;
    if (calm || $urandom_range(0, 1) == 0) begin
      return;
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    in_valid  <= 1'b0;
    op        <= 1'($urandom_range(0, 1));
    timestamp <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_transaction(input logic kind, input logic [TS_BITS-1:0] ts);
    in_valid  <= 1'b1;
    op        <= kind;
    timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (ts > latest_time) begin
      latest_time = ts;
    end
    sent_items++;
    idle_gap();
  endtask

  initial begin : receiver
    int run;
    int hold;
    bit held_long;
    out_stall = 1'b0;
    held_long = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && results_seen >= 40) begin
        hold = LONG_HOLD;
        held_long = 1'b1;
      end else if (calm || $urandom_range(0, 2) == 0) begin
        hold = 0;
      end else begin
        hold = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      run = $urandom_range(1, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic               kind;
    logic [TS_BITS-1:0] ts;
    int unsigned        pick;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_HIT;
    timestamp   = '0;
    latest_time = '0;
    sent_items  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Period edges, exact and one-past window gaps, and clamped timestamps.
    send_transaction(OP_QUERY, 0);
    send_transaction(OP_HIT, 0);
    send_transaction(OP_HIT, 1);
    send_transaction(OP_HIT, 1);
    send_transaction(OP_QUERY, 1);
    send_transaction(OP_HIT, 150);
    send_transaction(OP_HIT, 299);
    send_transaction(OP_HIT, 300);
    send_transaction(OP_QUERY, 300);
    send_transaction(OP_QUERY, 301);
    send_transaction(OP_HIT, 450);
    send_transaction(OP_QUERY, 600);
    send_transaction(OP_QUERY, 601);
    send_transaction(OP_HIT, 601);
    send_transaction(OP_HIT, 900);
    send_transaction(OP_QUERY, 901);
    send_transaction(OP_QUERY, 1202);
    send_transaction(OP_HIT, 5);
    send_transaction(OP_QUERY, 0);
    send_transaction(OP_HIT, 1501);
    send_transaction(OP_QUERY, 1502);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      kind = ($urandom_range(0, 4) < 2) ? OP_QUERY : OP_HIT;
      if (pick < 65) begin
        ts = later_time(latest_time, $urandom_range(0, 3));
      end else if (pick < 80) begin
        ts = later_time(latest_time, $urandom_range(4, WINDOW - 1));
      end else if (pick < 86) begin
        ts = later_time(latest_time, $urandom_range(WINDOW, WINDOW + 1));
      end else if (pick < 91) begin
        ts = later_time(latest_time, $urandom_range(WINDOW + 2, 2000));
      end else if (pick < 97) begin
        ts = $urandom_range(0, latest_time);
      end else begin
        ts = later_time(latest_time, $urandom_range(0, (32'hFFFF_FFFF - latest_time) / 8));
      end
      send_transaction(kind, ts);
    end

    send_transaction(OP_HIT, 32'hFFFF_FFFE);
    send_transaction(OP_HIT, 32'hFFFF_FFFF);
    send_transaction(OP_QUERY, 32'hFFFF_FFFF);
    send_transaction(OP_QUERY, 0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d hits, %0d queries, %0d window counts compared.",
             sent_items, hits_seen, queries_seen, results_seen);
    $display("Period rollovers %0d, window flushes %0d, clamped timestamps %0d, last time %0d.",
             rollovers_seen, flushes_seen, clamped_seen, latest_time);
    if (errors == 0 && pending == 0) begin
      $display("[sliding_window_hit_counter] OK");
    end else begin
      $display("[sliding_window_hit_counter] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd40_000_000);
    $display("[sliding_window_hit_counter] ERROR");
    $finish;
  end

endmodule
